FILE: sv/recv_frame_payload_extractor_defines.svh
// Assertion macros for the frame payload extractor; empty bodies under synthesis.
`ifndef RECV_FRAME_PAYLOAD_EXTRACTOR_DEFINES_SVH
`define RECV_FRAME_PAYLOAD_EXTRACTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RFPE_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rfpe check failed");
`define RFPE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfpe check failed");
`define RFPE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfpe check failed");
`else
`define RFPE_ASSERT_ALWAYS(lbl, cond)
`define RFPE_ASSERT_IMPL(lbl, ante, cons)
`define RFPE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/rfpe_pkg.sv
// Shared constants for the frame payload extractor.
`timescale 1ns / 1ps
package rfpe_pkg;
	localparam int BUF_DEPTH_DEF = 1024;
	localparam int LVL_W = 11;

	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [3:0] SKIP_MAX  = 4'd10;
	localparam logic [2:0] DIGIT_MAX = 3'd6;

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_R     = 4'd1;
	localparam logic [3:0] PH_RE    = 4'd2;
	localparam logic [3:0] PH_REC   = 4'd3;
	localparam logic [3:0] PH_RECV  = 4'd4;
	localparam logic [3:0] PH_QUOTE = 4'd5;
	localparam logic [3:0] PH_SKIP  = 4'd6;
	localparam logic [3:0] PH_LEN   = 4'd7;
	localparam logic [3:0] PH_CR    = 4'd8;
	localparam logic [3:0] PH_DATA  = 4'd9;
endpackage

FILE: sv/rfpe_if.sv
// Input and result channel interfaces of the frame payload extractor.
`timescale 1ns / 1ps
interface rfpe_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface rfpe_out_if import rfpe_pkg::*;;
	logic             valid;
	logic             ready;
	logic [7:0]       read_data;
	logic             read_ok;
	logic             frame_done;
	logic [LVL_W-1:0] fill_level;
	modport source (output valid, output read_data, output read_ok, output frame_done,
		output fill_level, input ready);
	modport sink (input valid, input read_data, input read_ok, input frame_done,
		input fill_level, output ready);
endinterface

FILE: sv/rfpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rfpe_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/recv_frame_payload_extractor.sv
// Modem frame parser with payload buffer and host byte FIFO.
// A modem byte that does not end a frame, or a read of an empty FIFO, goes straight to S_OUT;
// a read that pops passes S_RD first; a frame end passes S_PREP and S_COPY to copy its bytes.
// Throughput: one word at a time; the payload-to-FIFO copy moves one byte per cycle
// through the payload RAM read port.
// Reset (arst_n low, asynchronous): parser idle, FIFO empty; RAM contents are not cleared.
`timescale 1ns / 1ps
`include "recv_frame_payload_extractor_defines.svh"
module recv_frame_payload_extractor import rfpe_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rfpe_in_if.sink     in_ch,
	rfpe_out_if.source  out_ch
);
	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = $clog2(BUF_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_COPY = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]    state_q;
	logic [3:0]    ph_q, ph_d;
	logic [3:0]    skip_q, skip_d;
	logic [2:0]    dig_q, dig_d;
	logic [15:0]   len_q, len_d;
	logic [CW-1:0] idx_q, idx_d;
	logic          frame_end;

	logic [AW-1:0] head_q, tail_q;
	logic          wrap_q;
	logic [CW-1:0] lvl, free_cnt;
	logic          fifo_empty, fifo_full;

	logic [CW-1:0] cnt_q, iss_q;
	logic          pend_s1;
	logic          issue;

	logic [7:0]    rd_q;
	logic          ok_q, done_q;

	logic          acc, pay_we;
	logic [7:0]    pay_rdata, fifo_rdata;
	logic [CW-1:0] idx_inc;

	assign acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	assign lvl = (wrap_q ? CW'(BUF_DEPTH) : CW'(0)) + CW'(tail_q) - CW'(head_q);
	assign free_cnt = CW'(BUF_DEPTH) - lvl;
	assign fifo_empty = !wrap_q && (head_q == tail_q);
	assign fifo_full = wrap_q && (head_q == tail_q);

	assign idx_inc = idx_q + CW'(1);
	assign issue = (state_q == S_COPY) && (iss_q != cnt_q);
	assign pay_we = acc && (in_ch.cmd == CMD_RX) && (ph_q == PH_DATA);

	// Per-byte parser step
	always_comb begin
		ph_d = ph_q;
		skip_d = skip_q;
		dig_d = dig_q;
		len_d = len_q;
		idx_d = idx_q;
		frame_end = 1'b0;
		unique case (ph_q)
			PH_R: begin
				if (in_ch.rx_byte == CH_E) begin
					ph_d = PH_RE;
				end else if (in_ch.rx_byte != CH_R) begin
					ph_d = PH_IDLE;
				end
			end
			PH_RE: begin
				ph_d = (in_ch.rx_byte == CH_C) ? PH_REC :
					(in_ch.rx_byte == CH_R) ? PH_R : PH_IDLE;
			end
			PH_REC: begin
				ph_d = (in_ch.rx_byte == CH_V) ? PH_RECV :
					(in_ch.rx_byte == CH_R) ? PH_R : PH_IDLE;
			end
			PH_RECV: begin
				ph_d = (in_ch.rx_byte == CH_QUOTE) ? PH_QUOTE :
					(in_ch.rx_byte == CH_R) ? PH_R : PH_IDLE;
			end
			PH_QUOTE: begin
				ph_d = (in_ch.rx_byte == CH_COMMA) ? PH_SKIP :
					(in_ch.rx_byte == CH_R) ? PH_R : PH_IDLE;
				skip_d = 4'd0;
			end
			PH_SKIP: begin
				skip_d = skip_q + 4'd1;
				if (skip_d >= SKIP_MAX) begin
					ph_d = PH_IDLE;
				end else if (in_ch.rx_byte == CH_COMMA) begin
					ph_d = PH_LEN;
					dig_d = 3'd0;
					len_d = 16'd0;
				end
			end
			PH_LEN: begin
				if (in_ch.rx_byte == CH_CR) begin
					ph_d = PH_CR;
				end else begin
					// no digit check: any byte counts as value minus '0'
					len_d = (len_q << 3) + (len_q << 1) + 16'(in_ch.rx_byte) - 16'(CH_ZERO);
					dig_d = dig_q + 3'd1;
					if (dig_d >= DIGIT_MAX) begin
						ph_d = PH_IDLE;
					end
				end
			end
			PH_CR: begin
				if (in_ch.rx_byte == CH_LF && len_q <= 16'(BUF_DEPTH)) begin
					ph_d = PH_DATA;
					idx_d = '0;
				end else begin
					ph_d = PH_IDLE;
				end
			end
			PH_DATA: begin
				idx_d = idx_inc;
				if (16'(idx_inc) >= len_q) begin
					frame_end = 1'b1;
					ph_d = PH_IDLE;
				end
			end
			default: begin
				ph_d = (in_ch.rx_byte == CH_R) ? PH_R : PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= PH_IDLE;
			skip_q <= '0;
			dig_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			wrap_q <= 1'b0;
			cnt_q <= '0;
			iss_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (issue) begin
				iss_q <= iss_q + CW'(1);
			end
			if (pend_s1) begin
				if (tail_q == AW'(BUF_DEPTH - 1)) begin
					tail_q <= '0;
					wrap_q <= 1'b1;
				end else begin
					tail_q <= tail_q + AW'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (in_ch.cmd == CMD_READ) begin
							state_q <= fifo_empty ? S_OUT : S_RD;
						end else begin
							ph_q <= ph_d;
							skip_q <= skip_d;
							dig_q <= dig_d;
							len_q <= len_d;
							idx_q <= idx_d;
							state_q <= frame_end ? S_PREP : S_OUT;
						end
					end
				end
				S_PREP: begin
					// copy count is the smaller of the length and the free space
					cnt_q <= (len_q <= 16'(free_cnt)) ? CW'(len_q) : free_cnt;
					iss_q <= '0;
					state_q <= S_COPY;
				end
				S_COPY: begin
					if (!issue && !pend_s1) begin
						state_q <= S_OUT;
					end
				end
				S_RD: begin
					if (head_q == AW'(BUF_DEPTH - 1)) begin
						head_q <= '0;
						wrap_q <= 1'b0;
					end else begin
						head_q <= head_q + AW'(1);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word fields
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= 8'd0;
			ok_q <= 1'b0;
			done_q <= 1'b0;
		end
		if (state_q == S_RD) begin
			rd_q <= fifo_rdata;
			ok_q <= 1'b1;
		end
		if (state_q == S_COPY && !issue && !pend_s1) begin
			done_q <= 1'b1;
		end
	end

	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.read_data = rd_q;
	assign out_ch.read_ok = ok_q;
	assign out_ch.frame_done = done_q;
	assign out_ch.fill_level = LVL_W'(lvl);

	rfpe_ram #(.W(8), .DEPTH(BUF_DEPTH)) u_payload_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (in_ch.rx_byte),
		.raddr (iss_q[AW-1:0]),
		.rdata (pay_rdata)
	);

	rfpe_ram #(.W(8), .DEPTH(BUF_DEPTH)) u_fifo_ram (
		.clk   (clk),
		.we    (pend_s1),
		.waddr (tail_q),
		.wdata (pay_rdata),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	`RFPE_ASSERT_ALWAYS(a_level_bound, lvl <= CW'(BUF_DEPTH))
	`RFPE_ASSERT_IMPL(a_push_not_full, pend_s1, !fifo_full)
	`RFPE_ASSERT_IMPL(a_pop_not_empty, state_q == S_RD, !fifo_empty)
	`RFPE_ASSERT_IMPL(a_copy_bounded, state_q == S_COPY, iss_q <= cnt_q)
	`RFPE_ASSERT_NEXT(a_empty_read, acc && in_ch.cmd == CMD_READ && fifo_empty,
		out_ch.valid && !out_ch.read_ok)
endmodule
